### rtl/tpim_pkg.sv
`timescale 1ns / 1ps

package tpim_pkg;

  // filter shape
  localparam int TAPS       = 32;
  localparam int PHASES     = 4;
  localparam int COEF_WIDTH = 18;

  // datapath widths
  localparam int SAMPLE_W = 24;
  localparam int RAW_W    = 24;
  localparam int PEAK_W   = 25;
  localparam int FRAC_W   = COEF_WIDTH - 1;
  localparam int TAP_W    = $clog2(TAPS);
  localparam int ROM_N    = PHASES * TAPS;
  localparam int ROM_AW   = $clog2(ROM_N);
  localparam int PROD_W   = SAMPLE_W + COEF_WIDTH;
  localparam int ACC_W    = SAMPLE_W + COEF_WIDTH + TAP_W;
  localparam int RND_W    = ACC_W - FRAC_W;

  localparam logic [PEAK_W-1:0] TP_MAX = {PEAK_W{1'b1}};

  // angle grids of the two trig uses
  localparam longint SIN_DEN = 2 * PHASES;
  localparam longint WIN_DEN = TAPS - 1;
  localparam longint COS_DEN = 4 * WIN_DEN;

  localparam longint     ONE_Q30     = 64'sd1 << 30;
  localparam longint     PI_Q30      = 64'sd3373259426;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic signed [COEF_WIDTH-1:0] coef_t;
  typedef coef_t [ROM_N-1:0]            coef_rom_t;
  typedef logic signed [SAMPLE_W-1:0]   sample_t;

  // shift and subtract quotient, used only while the table is built
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint mag_l(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // signed quotient, truncated toward zero
  function automatic longint sdiv64(input longint num, input longint den);
    logic [63:0] q;
    q = udiv64(64'(mag_l(num)), 64'(mag_l(den)));
    return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
  endfunction

  // elaboration-time trig: sin over the first quadrant, taylor series in q30
  function automatic longint quarter_sin(input longint m, input bit on_cos_grid);
    logic [63:0] den;
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] term;
    logic [63:0] acc;
    den  = on_cos_grid ? 64'(COS_DEN) : 64'(SIN_DEN);
    a    = udiv64(HALF_PI_Q30 * 64'(m), den);
    a2   = (a * a) >> 30;
    term = a;
    acc  = a;
    for (int i = 1; i <= 9; i++) begin
      term = udiv64((term * a2) >> 30, 64'((2 * i) * (2 * i + 1)));
      if ((i % 2) == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    return longint'(acc);
  endfunction

  // sin of a fraction of a turn on one of the two grids
  function automatic longint sin_turns(input longint num, input bit on_cos_grid);
    longint den;
    longint r;
    longint q4;
    longint k;
    longint rem;
    den = on_cos_grid ? COS_DEN : SIN_DEN;
    r   = num - sdiv64(num, den) * den;
    if (r < 0) begin
      r = r + den;
    end
    q4  = 4 * r;
    k   = sdiv64(q4, den);
    rem = q4 - k * den;
    case (k)
      64'sd0:  return quarter_sin(rem, on_cos_grid);
      64'sd1:  return quarter_sin(den - rem, on_cos_grid);
      64'sd2:  return -quarter_sin(rem, on_cos_grid);
      default: return -quarter_sin(den - rem, on_cos_grid);
    endcase
  endfunction

  // cos(2 pi num / (TAPS-1)) for the window
  function automatic longint cos_win(input longint num);
    return sin_turns(4 * num + WIN_DEN, 1'b1);
  endfunction

  function automatic longint mul_q30(input longint a, input longint b);
    logic [63:0] r;
    r = (64'(mag_l(a)) * 64'(mag_l(b))) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  // windowed-sinc polyphase table, unity dc gain per phase
  function automatic coef_rom_t build_rom();
    coef_rom_t   rom;
    longint      taps [TAPS];
    longint      n;
    longint      s;
    longint      sinc;
    longint      win;
    longint      sum;
    longint      c;
    longint      lim;
    logic [63:0] m;
    lim = 64'sd1 <<< FRAC_W;
    for (int p = 0; p < PHASES; p++) begin
      sum = 0;
      for (int t = 0; t < TAPS; t++) begin
        n = longint'(PHASES) * (longint'(t) - longint'(TAPS / 2 - 1)) - longint'(p);
        if (n == 0) begin
          sinc = ONE_Q30;
        end else begin
          s    = sin_turns(n, 1'b0);
          sinc = sdiv64(s * ONE_Q30, PI_Q30);
          sinc = sdiv64(sinc * longint'(PHASES), n);
        end
        win = sdiv64(64'sd35875 * ONE_Q30 - 64'sd48829 * cos_win(longint'(t))
                     + 64'sd14128 * cos_win(2 * longint'(t))
                     - 64'sd1168 * cos_win(3 * longint'(t)), 64'sd100000);
        taps[t] = mul_q30(sinc, win);
        sum     = sum + taps[t];
      end
      if (sum < 1) begin
        sum = 1;
      end
      for (int t = 0; t < TAPS; t++) begin
        m = 64'(mag_l(taps[t]));
        c = longint'(udiv64((m << FRAC_W) + 64'(sum / 2), 64'(sum)));
        if (taps[t] < 0) begin
          c = -c;
        end
        if (c > lim - 1) begin
          c = lim - 1;
        end
        if (c < -lim) begin
          c = -lim;
        end
        rom[p * TAPS + t] = COEF_WIDTH'(c);
      end
    end
    return rom;
  endfunction

  localparam coef_rom_t COEF_ROM = build_rom();

  // control flags that travel with each pipeline stage
  typedef struct packed {
    logic valid;
    logic last_tap;
    logic last_item;
  } stage_flags_t;

endpackage

### rtl/true_peak_interpolating_meter.sv
`timescale 1ns / 1ps

// True-peak meter with polyphase interpolation.
// Input channel: sample_i with in_valid_i / in_stall_o; an item is taken on a
// rising edge with in_valid_i high and in_stall_o low.
// Output channel: sample_peak_o and true_peak_o with out_valid_o / out_stall_i.
// Every input item yields exactly one result item carrying the peak holds.
// Per item the history ring is rotated past a single multiply-accumulate unit,
// one tap per cycle, for all phases: PHASES*TAPS = 128 taps are issued and pass
// through the fetch, multiply, accumulate, magnitude and hold pipeline. The next
// item is taken only once the result of the last one sits in the output register,
// so the single shared MAC never works on two items at once.
// While the receiver stalls, the result stays on the output ports and a new
// item can still be taken and processed; its result waits for the register.
// Reset (rst_ni low, asynchronous) clears the sample history, the tap and table
// indices, both peak holds and all valid flags.

module true_peak_interpolating_meter
  import tpim_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [SAMPLE_W-1:0] sample_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [RAW_W-1:0]    sample_peak_o,
  output logic [PEAK_W-1:0]   true_peak_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  state_e state_q;

  // history ring, oldest sample at index 0
  sample_t hist_q [TAPS];

  logic [TAP_W-1:0]  tap_q;
  logic [ROM_AW-1:0] rom_idx_q;

  logic [RAW_W-1:0]  raw_hold_q;
  logic [PEAK_W-1:0] interp_hold_q;

  logic              out_valid_q;
  logic [RAW_W-1:0]  sample_peak_q;
  logic [PEAK_W-1:0] true_peak_q;

  // pipeline payload
  sample_t                    samp_q;
  coef_t                      coef_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [ACC_W-1:0]    fin_q;
  logic [ACC_W-1:0]           abs_q;
  logic [PEAK_W-1:0]          mag_q;

  stage_flags_t f0_q, f1_q, f2_q, f3_q, f4_q;

  logic                       in_take;
  logic                       issue;
  logic                       out_free;
  logic [RAW_W-1:0]           smag;
  logic signed [PROD_W-1:0]   prod_d;
  logic signed [ACC_W-1:0]    acc_sum;
  logic [ACC_W-1:0]           abs_d;
  logic [RND_W-1:0]           rnd;
  logic [PEAK_W-1:0]          mag_d;
  logic [PEAK_W-1:0]          tp_d;

  assign in_take  = in_valid_i && (state_q == ST_IDLE);
  assign issue    = (state_q == ST_RUN);
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign sample_peak_o = sample_peak_q;
  assign true_peak_o   = true_peak_q;

  // magnitude of the incoming sample, most negative value fits unsigned
  assign smag = sample_i[SAMPLE_W-1] ? RAW_W'(-sample_i) : RAW_W'(sample_i);

  // datapath arithmetic
  assign prod_d  = samp_q * coef_q;
  assign acc_sum = acc_q + ACC_W'(prod_q);
  assign abs_d   = fin_q[ACC_W-1] ? ACC_W'(-fin_q) : ACC_W'(fin_q);
  assign rnd     = RND_W'((abs_q + ACC_W'(1) * (ACC_W'(1) << (FRAC_W - 1))) >> FRAC_W);
  assign mag_d   = (rnd > RND_W'(TP_MAX)) ? TP_MAX : rnd[PEAK_W-1:0];
  assign tp_d    = (interp_hold_q > {1'b0, raw_hold_q}) ? interp_hold_q : {1'b0, raw_hold_q};

  // history ring: shift in on a new item, rotate once per tap while running
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAPS; i++) begin
        hist_q[i] <= '0;
      end
    end else if (in_take) begin
      for (int i = 0; i < TAPS - 1; i++) begin
        hist_q[i] <= hist_q[i + 1];
      end
      hist_q[TAPS-1] <= sample_t'(sample_i);
    end else if (issue) begin
      for (int i = 0; i < TAPS - 1; i++) begin
        hist_q[i] <= hist_q[i + 1];
      end
      hist_q[TAPS-1] <= hist_q[0];
    end
  end

  // sequencer, peak holds and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      tap_q         <= '0;
      rom_idx_q     <= '0;
      raw_hold_q    <= '0;
      interp_hold_q <= '0;
      out_valid_q   <= 1'b0;
      sample_peak_q <= '0;
      true_peak_q   <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      if (f4_q.valid && (mag_q > interp_hold_q)) begin
        interp_hold_q <= mag_q;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            if (smag > raw_hold_q) begin
              raw_hold_q <= smag;
            end
            tap_q     <= '0;
            rom_idx_q <= '0;
            state_q   <= ST_RUN;
          end
        end
        ST_RUN: begin
          tap_q     <= (tap_q == TAP_W'(TAPS - 1)) ? '0 : tap_q + 1'b1;
          rom_idx_q <= rom_idx_q + 1'b1;
          if (rom_idx_q == ROM_AW'(ROM_N - 1)) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (f4_q.valid && f4_q.last_item) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            sample_peak_q <= raw_hold_q;
            true_peak_q   <= tp_d;
            state_q       <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // pipeline flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f0_q <= '0;
      f1_q <= '0;
      f2_q <= '0;
      f3_q <= '0;
      f4_q <= '0;
    end else begin
      f0_q.valid     <= issue;
      f0_q.last_tap  <= (tap_q == TAP_W'(TAPS - 1));
      f0_q.last_item <= (rom_idx_q == ROM_AW'(ROM_N - 1));
      f1_q           <= f0_q;
      // one result per phase leaves the accumulator
      f2_q.valid     <= f1_q.valid && f1_q.last_tap;
      f2_q.last_tap  <= f1_q.last_tap;
      f2_q.last_item <= f1_q.last_item;
      f3_q           <= f2_q;
      f4_q           <= f3_q;
    end
  end

  // tap fetch and coefficient table read
  always_ff @(posedge clk_i) begin
    if (issue) begin
      samp_q <= hist_q[0];
      coef_q <= COEF_ROM[rom_idx_q];
    end
  end

  // multiply
  always_ff @(posedge clk_i) begin
    if (f0_q.valid) begin
      prod_q <= prod_d;
    end
  end

  // accumulate, restart at each phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (f1_q.valid) begin
      if (f1_q.last_tap) begin
        acc_q <= '0;
      end else begin
        acc_q <= acc_sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (f1_q.valid && f1_q.last_tap) begin
      fin_q <= acc_sum;
    end
  end

  // magnitude, then round, scale and saturate
  always_ff @(posedge clk_i) begin
    if (f2_q.valid) begin
      abs_q <= abs_d;
    end
    if (f3_q.valid) begin
      mag_q <= mag_d;
    end
  end

endmodule

### rtl/tpim_checker.sv
`timescale 1ns / 1ps

module tpim_checker
  import tpim_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic [SAMPLE_W-1:0] sample_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [RAW_W-1:0]    sample_peak_o,
  input logic [PEAK_W-1:0]   true_peak_o
);

  // a held result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a held result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(true_peak_o) && $stable(sample_peak_o))
    else $error("result changed while stalled");

  // true peak never falls below sample peak
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> true_peak_o >= {1'b0, sample_peak_o})
    else $error("true peak below sample peak");

  // sample peak is bounded by full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sample_peak_o <= (RAW_W'(1) << (SAMPLE_W - 1)))
    else $error("sample peak beyond full scale");

  // the block is busy right after taking an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while busy");

endmodule

bind true_peak_interpolating_meter tpim_checker u_tpim_checker (.*);

### tb/tpim_peak_monitor.sv
`timescale 1ns / 1ps

module tpim_peak_monitor
  import tpim_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [RAW_W-1:0]    sample_peak_i,
  input  logic [PEAK_W-1:0]   true_peak_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam longint      Q30_ONE      = 64'sd1 << 30;
  localparam longint      Q30_PI       = 64'sd3373259426;
  localparam logic [63:0] Q30_HALF_PI  = 64'd1686629713;
  localparam int          SHIFT        = COEF_WIDTH - 1;
  localparam int          CENTRE       = TAPS / 2 - 1;
  localparam logic [PEAK_W-1:0] PEAK_CEIL = {PEAK_W{1'b1}};
  localparam int          REPORT_LIMIT = 10;

  typedef struct packed {
    logic [RAW_W-1:0]  sample_peak;
    logic [PEAK_W-1:0] peak_max;
  } peak_report_t;

  // meter state as seen from outside
  longint            coef_table [PHASES][TAPS];
  sample_t           ring [TAPS];
  int unsigned       ring_pos;
  logic [RAW_W-1:0]  raw_hold;
  logic [PEAK_W-1:0] interp_hold;

  peak_report_t reports_due [$];
  int           mismatches;
  int           results_seen;

  function automatic longint abs64(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // q30 product, truncated on the magnitude
  function automatic longint q30_product(input longint a, input longint b);
    logic [63:0] r;
    r = ($unsigned(abs64(a)) * $unsigned(abs64(b))) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  // sin(pi/2 * m / den) by taylor series, q30
  function automatic longint quadrant_sine(input longint m, input longint den);
    logic [63:0] ang;
    logic [63:0] ang_sq;
    logic [63:0] term;
    longint      total;
    int          i;
    ang    = (Q30_HALF_PI * $unsigned(m)) / $unsigned(den);
    ang_sq = (ang * ang) >> 30;
    term   = ang;
    total  = longint'(ang);
    for (i = 1; i <= 9; i++) begin
      term = ((term * ang_sq) >> 30) / 64'((2 * i) * (2 * i + 1));
      if ((i % 2) == 1) begin
        total = total - longint'(term);
      end else begin
        total = total + longint'(term);
      end
    end
    return total;
  endfunction

  // sin(2 pi num / den) folded onto the first quadrant
  function automatic longint turn_sine(input longint num, input longint den);
    longint r;
    longint q4;
    longint k;
    longint rem;
    r = num % den;
    if (r < 0) begin
      r = r + den;
    end
    q4  = 4 * r;
    k   = q4 / den;
    rem = q4 - k * den;
    if (k == 0) begin
      return quadrant_sine(rem, den);
    end else if (k == 1) begin
      return quadrant_sine(den - rem, den);
    end else if (k == 2) begin
      return -quadrant_sine(rem, den);
    end
    return -quadrant_sine(den - rem, den);
  endfunction

  function automatic longint turn_cosine(input longint num, input longint den);
    return turn_sine(4 * num + den, 4 * den);
  endfunction

  // windowed-sinc interpolation table, each phase normalised to unity gain
  task automatic fill_coef_table();
    longint      tap [TAPS];
    longint      n;
    longint      s;
    longint      sinc;
    longint      win;
    longint      sum;
    longint      c;
    longint      lim;
    longint      wden;
    logic [63:0] mag;
    int          p;
    int          t;
    lim  = 64'sd1 <<< SHIFT;
    wden = TAPS - 1;
    for (p = 0; p < PHASES; p++) begin
      sum = 0;
      for (t = 0; t < TAPS; t++) begin
        n = longint'(PHASES) * (longint'(t) - longint'(CENTRE)) - longint'(p);
        if (n == 0) begin
          sinc = Q30_ONE;
        end else begin
          s    = turn_sine(n, 2 * longint'(PHASES));
          sinc = (s * Q30_ONE) / Q30_PI;
          sinc = (sinc * longint'(PHASES)) / n;
        end
        win = (64'sd35875 * Q30_ONE
               - 64'sd48829 * turn_cosine(longint'(t), wden)
               + 64'sd14128 * turn_cosine(2 * longint'(t), wden)
               - 64'sd1168 * turn_cosine(3 * longint'(t), wden)) / 64'sd100000;
        tap[t] = q30_product(sinc, win);
        sum    = sum + tap[t];
      end
      if (sum < 1) begin
        sum = 1;
      end
      for (t = 0; t < TAPS; t++) begin
        mag = $unsigned(abs64(tap[t]));
        c   = longint'(((mag << SHIFT) + $unsigned(sum / 2)) / $unsigned(sum));
        if (tap[t] < 0) begin
          c = -c;
        end
        // the centre tap of phase zero would be exactly one and clips
        if (c > lim - 1) begin
          c = lim - 1;
        end
        if (c < -lim) begin
          c = -lim;
        end
        coef_table[p][t] = c;
      end
    end
  endtask

  // take one sample, update both holds and return the reported peaks
  task automatic advance_meter(input sample_t s, output peak_report_t r);
    longint            lmag;
    longint            acc;
    logic [63:0]       amag;
    logic [63:0]       rounded;
    logic [PEAK_W-1:0] phase_peak;
    int unsigned       idx;
    int                p;
    int                t;
    lmag = abs64(longint'(s));
    if (RAW_W'(lmag) > raw_hold) begin
      raw_hold = RAW_W'(lmag);
    end
    ring[ring_pos] = s;
    ring_pos = (ring_pos + 1 == TAPS) ? 0 : ring_pos + 1;
    for (p = 0; p < PHASES; p++) begin
      acc = 0;
      for (t = 0; t < TAPS; t++) begin
        idx = ring_pos + t;
        if (idx >= TAPS) begin
          idx = idx - TAPS;
        end
        acc = acc + longint'(ring[idx]) * coef_table[p][t];
      end
      amag    = $unsigned(abs64(acc));
      rounded = (amag + (64'd1 << (SHIFT - 1))) >> SHIFT;
      // four times full scale is the ceiling
      phase_peak = (rounded > 64'(PEAK_CEIL)) ? PEAK_CEIL : PEAK_W'(rounded);
      if (phase_peak > interp_hold) begin
        interp_hold = phase_peak;
      end
    end
    r.sample_peak = raw_hold;
    r.peak_max    = (interp_hold > PEAK_W'(raw_hold)) ? interp_hold : PEAK_W'(raw_hold);
  endtask

  // table and cleared state before the first item
  initial begin
    fill_coef_table();
    foreach (ring[k]) begin
      ring[k] = '0;
    end
    ring_pos     = 0;
    raw_hold     = '0;
    interp_hold  = '0;
    mismatches   = 0;
    results_seen = 0;
  end

  // compare each result taken, then predict for each item taken
  always @(posedge clk_i) begin : watch
    peak_report_t want;
    peak_report_t got;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        got.sample_peak = sample_peak_i;
        got.peak_max    = true_peak_i;
        if (reports_due.size() == 0) begin
          if (mismatches < REPORT_LIMIT) begin
            $display("%0t: result %0d with no item waiting: sample peak %0d true peak %0d",
                     $time, results_seen, got.sample_peak, got.peak_max);
          end
          mismatches++;
        end else begin
          want = reports_due.pop_front();
          if (got.sample_peak !== want.sample_peak || got.peak_max !== want.peak_max) begin
            if (mismatches < REPORT_LIMIT) begin
              $display("%0t: result %0d: sample peak exp %0d got %0d, true peak exp %0d got %0d",
                       $time, results_seen, want.sample_peak, got.sample_peak,
                       want.peak_max, got.peak_max);
            end
            mismatches++;
          end
        end
        results_seen++;
      end
      if (in_valid_i && !in_stall_i) begin
        advance_meter(sample_i, want);
        reports_due.insert(reports_due.size(), want);
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= reports_due.size();
  end

endmodule

### tb/true_peak_interpolating_meter_test.sv
`timescale 1ns / 1ps

module true_peak_interpolating_meter_test
  import tpim_pkg::*;
();

  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 9;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 595;
  localparam int DRAIN_CYCLES = 300;
  localparam int SAMPLE_MAX   = 2 ** (SAMPLE_W - 1) - 1;
  localparam int SAMPLE_MIN   = -(2 ** (SAMPLE_W - 1));

  typedef enum int {
    BURST_NOISE,
    BURST_HALF_MATCH,
    BURST_QUARTER_TONE,
    BURST_NYQUIST
  } burst_kind_e;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [SAMPLE_W-1:0] sample_i    = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [RAW_W-1:0]    sample_peak_o;
  logic [PEAK_W-1:0]   true_peak_o;

  int fail_count;
  int pending;
  int cycle_count = 0;
  bit tx_calm     = 1'b0;
  bit rx_calm     = 1'b0;
  int rx_hold     = 0;

  always #CLK_HALF clk_i = ~clk_i;

  true_peak_interpolating_meter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_i      (sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sample_peak_o (sample_peak_o),
    .true_peak_o   (true_peak_o)
  );

  tpim_peak_monitor peak_monitor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .sample_i      (sample_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sample_peak_i (sample_peak_o),
    .true_peak_i   (true_peak_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // offer one item after a random gap and wait until it is taken
  task automatic push_sample(input int value);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= SAMPLE_W'(value);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // sample j of a burst; the half match follows the sign pattern of the
  // half-sample phase so that the inter-sample peak rises above the samples
  function automatic int burst_value(input burst_kind_e kind, input int j, input int amp);
    int jj;
    int d;
    int v;
    jj = j % TAPS;
    d  = (jj <= TAPS / 2 - 1) ? TAPS / 2 - 1 - jj : jj - TAPS / 2;
    case (kind)
      BURST_NOISE: begin
        v = int'($urandom_range(0, 2 * amp)) - amp;
      end
      BURST_HALF_MATCH: begin
        v = ((d % 2) == 0) ? amp : -amp;
      end
      BURST_QUARTER_TONE: begin
        v = (((j / 2) % 2) == 0) ? amp : -amp;
      end
      default: begin
        v = ((j % 2) == 0) ? amp : -amp;
      end
    endcase
    if (v > SAMPLE_MAX) begin
      v = SAMPLE_MAX;
    end
    if (v < SAMPLE_MIN) begin
      v = SAMPLE_MIN;
    end
    return v;
  endfunction

  // result side: random hold-off per result, counted while a result waits
  always @(posedge clk_i or negedge rst_ni) begin : result_sink
    int draw;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_hold     <= 0;
      rx_calm     <= 1'b0;
    end else if (out_valid_o && !out_stall_i) begin
      draw = rx_calm ? 0 : $urandom_range(0, 16);
      if ($urandom_range(0, 7) == 0) begin
        rx_calm <= ~rx_calm;
      end
      rx_hold     <= draw;
      out_stall_i <= (draw != 0);
    end else if (out_valid_o && rx_hold != 0) begin
      rx_hold     <= rx_hold - 1;
      out_stall_i <= (rx_hold > 1);
    end
  end

  // run-length guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int          opening [21] = '{0, 1, -1, 0, 0, 2, -3,
                                  8, 8, -8, -8, 8, 8, -8, -8,
                                  16, -16, 16, -16, 16, -16};
    int          sent;
    int          len;
    int          amp;
    int          expo;
    int          j;
    bit          paused;
    burst_kind_e kind;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // low-level opening: zero, unit steps, small tones at quarter and half rate
    foreach (opening[k]) begin
      push_sample(opening[k]);
    end

    // random bursts, amplitude rising over the run so that both holds keep moving
    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      kind    = burst_kind_e'($urandom_range(0, 3));
      len     = $urandom_range(1, 40);
      tx_calm = ($urandom_range(0, 4) == 0);
      expo    = 4 + (sent * 20) / RANDOM_ITEMS;
      amp     = $urandom_range(1 << (expo - 1), 1 << expo);
      for (j = 0; j < len && sent < RANDOM_ITEMS; j++) begin
        push_sample(burst_value(kind, j, amp));
        sent++;
      end
      // once midway, let the meter drain completely before going on
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        paused     = 1'b1;
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
    end

    // full-scale extremes come last, as they pin the holds for good
    tx_calm = 1'b0;
    push_sample(SAMPLE_MAX);
    push_sample(SAMPLE_MIN);
    for (j = 0; j < TAPS; j++) begin
      push_sample(burst_value(BURST_HALF_MATCH, j, SAMPLE_MAX + 1));
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
